// File: hw/rtl/tdmf_pkg.sv
// Shared types, widths, register codes and the duty lookup table for the
// tank drive mixer with failsafe. No dependencies; used by every RTL file.
package tdmf_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int DUTY_BITS   = 10;
   localparam int PCT_BITS    = 7;
   localparam int PCT_FULL    = 100;
   localparam int NUM_W       = SAMPLE_BITS + PCT_BITS;
   localparam int CNT_W       = $clog2(NUM_W + 1);
   localparam int LIMIT_BITS  = 7;
   localparam int TIMER_BITS  = 16;
   localparam int CMD_BITS    = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = (SAMPLE_BITS > TIMER_BITS) ? SAMPLE_BITS : TIMER_BITS;
   localparam int REQ_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((4 * DUTY_BITS + 7) / 8) * 8;
   localparam int RSP_USER_W  = 4;
   localparam int PCT_LUT_DEPTH = 1 << PCT_BITS;
   localparam int NUM_DUTIES  = 4;

   localparam int DUTY_LF = 0;
   localparam int DUTY_LB = 1;
   localparam int DUTY_RF = 2;
   localparam int DUTY_RB = 3;

   localparam logic [SAMPLE_BITS-1:0] DB_LOW_RESET     = SAMPLE_BITS'(1920);
   localparam logic [SAMPLE_BITS-1:0] DB_HIGH_RESET    = SAMPLE_BITS'(2050);
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE_RESET = SAMPLE_BITS'(4095);
   localparam logic [LIMIT_BITS-1:0]  DUTY_LIMIT_RESET = LIMIT_BITS'(35);
   localparam logic                   LIMIT_EN_RESET   = 1'b1;
   localparam logic [TIMER_BITS-1:0]  TIMEOUT_RESET    = TIMER_BITS'(500);

   localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_STOP   = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_HELD  = 3'd0,
      MODE_FWD   = 3'd1,
      MODE_BACK  = 3'd2,
      MODE_ROT_L = 3'd3,
      MODE_ROT_R = 3'd4,
      MODE_STOP  = 3'd5
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DB_LOW     = 3'd0,
      REG_DB_HIGH    = 3'd1,
      REG_FULL_SCALE = 3'd2,
      REG_DUTY_LIMIT = 3'd3,
      REG_LIMIT_EN   = 3'd4,
      REG_TIMEOUT    = 3'd5
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PCT_Y,
      ST_WAIT_Y,
      ST_PCT_X,
      ST_WAIT_X,
      ST_MIX,
      ST_COMMIT,
      ST_OUT
   } st_type;

   typedef logic [DUTY_BITS-1:0] duty_lut_type [PCT_LUT_DEPTH];

   // Percent to duty count, saturated at full scale.
   function automatic duty_lut_type build_duty_lut();
      duty_lut_type lut;
      for (int i = 0; i < PCT_LUT_DEPTH; i++) begin
         lut[i] = (i >= PCT_FULL) ? DUTY_MAX : DUTY_BITS'((i << DUTY_BITS) / PCT_FULL);
      end
      return lut;
   endfunction

   localparam duty_lut_type DUTY_LUT = build_duty_lut();

   function automatic logic [DUTY_BITS-1:0] to_duty(input logic [NUM_W-1:0] pct);
      if (pct >= NUM_W'(PCT_FULL)) begin
         return DUTY_MAX;
      end
      return DUTY_LUT[pct[PCT_BITS-1:0]];
   endfunction

endpackage

// File: hw/rtl/tdmf_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tdmf_pkg for operand widths.
module tdmf_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tdmf_pkg::NUM_W-1:0]       num,
   input  logic [tdmf_pkg::SAMPLE_BITS-1:0] den,
   output logic                             done,
   output logic [tdmf_pkg::NUM_W-1:0]       quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [tdmf_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [tdmf_pkg::SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [tdmf_pkg::SAMPLE_BITS-1:0] den_ff, den_in;
   logic [tdmf_pkg::NUM_W-1:0]       quo_ff, quo_in;

   logic [tdmf_pkg::SAMPLE_BITS:0]   trial;
   logic [tdmf_pkg::SAMPLE_BITS:0]   trial_sub;
   logic                             fits;

   assign trial     = {rem_ff, quo_ff[tdmf_pkg::NUM_W-1]};
   assign fits      = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract where it fits
         rem_in = fits ? trial_sub[tdmf_pkg::SAMPLE_BITS-1:0]
                       : trial[tdmf_pkg::SAMPLE_BITS-1:0];
         quo_in = {quo_ff[tdmf_pkg::NUM_W-2:0], fits};
         cnt_in = cnt_ff + tdmf_pkg::CNT_W'(1);
         if (cnt_ff == tdmf_pkg::CNT_W'(tdmf_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff))
      else $error("divider remainder reached divisor");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");
`endif

endmodule

// File: hw/rtl/tank_drive_mixer_failsafe.sv
// Top level: joystick to tank drive duty mixer with failsafe timer.
// Depends on tdmf_pkg (types, table) and tdmf_div (shared divider).
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  req     | in        | req_tvalid / req_tready  | tuser command, tdata x then y
//  rsp     | out       | rsp_tvalid / rsp_tready  | tdata four duties, tuser mode+timeout
//  csr     | in        | csr_wr_en (no wait)      | csr_index, csr_wdata
//
// A joystick sample takes the percent steps for y, then x; each axis whose
// percent needs it runs the shared restoring divider, one quotient bit a cycle,
// and the mix and commit steps follow before the result is offered on rsp.
// Stop, tick and ignored commands give their result in the cycle after accept.
// One item is in flight at a time; req_tready is high only while idle, and
// the result holds on rsp until taken. Reset is synchronous and restores the
// register defaults, zero duties and a disarmed timer.
module tank_drive_mixer_failsafe (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tdmf_pkg::REQ_DATA_W-1:0]    req_tdata,  // steer_x, throttle_y
   input  logic [tdmf_pkg::CMD_BITS-1:0]      req_tuser,  // command
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tdmf_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // left_fwd, left_back,
                                                          // right_fwd, right_back
   output logic [tdmf_pkg::RSP_USER_W-1:0]    rsp_tuser,  // motion_mode, stopped_by_timeout
   // configuration
   input  logic                               csr_wr_en,
   input  logic [tdmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tdmf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SB = tdmf_pkg::SAMPLE_BITS;
   localparam int NW = tdmf_pkg::NUM_W;
   localparam int DB = tdmf_pkg::DUTY_BITS;

   // configuration registers
   logic [SB-1:0]                    db_low_ff;
   logic [SB-1:0]                    db_high_ff;
   logic [SB-1:0]                    full_scale_ff;
   logic [tdmf_pkg::LIMIT_BITS-1:0]  duty_limit_ff;
   logic                             limit_en_ff;
   logic [tdmf_pkg::TIMER_BITS-1:0]  timeout_ff;

   // sequencer and state
   tdmf_pkg::st_type                 state_ff, state_in;
   logic [SB-1:0]                    x_ff, x_in;
   logic [SB-1:0]                    y_ff, y_in;
   logic [NW-1:0]                    yp_ff, yp_in;
   logic [NW-1:0]                    xp_ff, xp_in;
   logic [NW-1:0]                    left_ff, left_in;
   logic [NW-1:0]                    right_ff, right_in;
   logic [DB-1:0]                    duty_ff [tdmf_pkg::NUM_DUTIES];
   logic [DB-1:0]                    duty_in [tdmf_pkg::NUM_DUTIES];
   tdmf_pkg::mode_type               mode_ff, mode_in;
   logic                             expired_ff, expired_in;
   logic [tdmf_pkg::TIMER_BITS-1:0]  count_ff, count_in;
   logic                             armed_ff, armed_in;

   // shared divider hookup
   logic                             div_start;
   logic [NW-1:0]                    div_num;
   logic [SB-1:0]                    div_den;
   logic                             div_done;
   logic [NW-1:0]                    div_quo;

   // operand selection for the percent steps
   logic [SB-1:0]                    v_sel;
   logic                             v_hi, v_lo, span_ok, need_div;
   logic [NW-1:0]                    pct_direct;

   // mixing
   logic [NW-1:0]                    mix_diff;
   logic [NW-1:0]                    limit_w;
   logic [NW-1:0]                    mix_left, mix_right;
   logic                             is_fwd, is_back, is_rot_l, is_rot_r;
   logic [DB-1:0]                    left_duty, right_duty;

   tdmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Pick the axis for the current percent step; high side test comes first.
   assign v_sel    = (state_ff == tdmf_pkg::ST_PCT_X) ? x_ff : y_ff;
   assign v_hi     = v_sel > db_high_ff;
   assign v_lo     = v_sel < db_low_ff;
   assign span_ok  = full_scale_ff > db_high_ff;
   assign need_div = (v_hi && span_ok) || (!v_hi && v_lo);
   // flat span above the deadband reads as full percent
   assign pct_direct = v_hi ? NW'(tdmf_pkg::PCT_FULL) : '0;
   assign div_num = v_hi ? NW'(v_sel - db_high_ff) * NW'(tdmf_pkg::PCT_FULL)
                         : NW'(db_low_ff - v_sel) * NW'(tdmf_pkg::PCT_FULL);
   assign div_den = v_hi ? (full_scale_ff - db_high_ff) : db_low_ff;

   // Steering replaces one side with |x% - y%|, then clamps when limiting is on.
   assign mix_diff = (xp_ff > yp_ff) ? (xp_ff - yp_ff) : (yp_ff - xp_ff);
   assign is_fwd   = y_ff > db_high_ff;
   assign is_back  = !is_fwd && (y_ff < db_low_ff);
   assign is_rot_l = x_ff > db_high_ff;
   assign is_rot_r = !is_rot_l && (x_ff < db_low_ff);
   assign limit_w  = NW'(duty_limit_ff);

   always_comb begin
      mix_left  = is_rot_l ? mix_diff : yp_ff;
      mix_right = is_rot_r ? mix_diff : yp_ff;
      if (limit_en_ff) begin
         if (mix_left > limit_w) begin
            mix_left = limit_w;
         end
         if (mix_right > limit_w) begin
            mix_right = limit_w;
         end
      end
   end

   assign left_duty  = tdmf_pkg::to_duty(left_ff);
   assign right_duty = tdmf_pkg::to_duty(right_ff);

   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      yp_in      = yp_ff;
      xp_in      = xp_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      duty_in    = duty_ff;
      mode_in    = mode_ff;
      expired_in = expired_ff;
      count_in   = count_ff;
      armed_in   = armed_ff;
      div_start  = 1'b0;

      case (state_ff)
         tdmf_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mode_in    = tdmf_pkg::MODE_HELD;
               expired_in = 1'b0;
               state_in   = tdmf_pkg::ST_OUT;
               case (tdmf_pkg::cmd_type'(req_tuser))
                  tdmf_pkg::CMD_SAMPLE: begin
                     x_in     = req_tdata[SB-1:0];
                     y_in     = req_tdata[2*SB-1:SB];
                     state_in = tdmf_pkg::ST_PCT_Y;
                  end
                  tdmf_pkg::CMD_STOP: begin
                     for (int i = 0; i < tdmf_pkg::NUM_DUTIES; i++) begin
                        duty_in[i] = '0;
                     end
                     armed_in = 1'b0;
                     count_in = '0;
                     mode_in  = tdmf_pkg::MODE_STOP;
                  end
                  tdmf_pkg::CMD_TICK: begin
                     if (armed_ff) begin
                        if (count_ff <= tdmf_pkg::TIMER_BITS'(1)) begin
                           // failsafe expiry: drop all duties
                           for (int i = 0; i < tdmf_pkg::NUM_DUTIES; i++) begin
                              duty_in[i] = '0;
                           end
                           armed_in   = 1'b0;
                           count_in   = '0;
                           mode_in    = tdmf_pkg::MODE_STOP;
                           expired_in = 1'b1;
                        end else begin
                           count_in = count_ff - tdmf_pkg::TIMER_BITS'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         tdmf_pkg::ST_PCT_Y: begin
            if (need_div) begin
               div_start = 1'b1;
               state_in  = tdmf_pkg::ST_WAIT_Y;
            end else begin
               yp_in    = pct_direct;
               state_in = tdmf_pkg::ST_PCT_X;
            end
         end
         tdmf_pkg::ST_WAIT_Y: begin
            if (div_done) begin
               yp_in    = div_quo;
               state_in = tdmf_pkg::ST_PCT_X;
            end
         end
         tdmf_pkg::ST_PCT_X: begin
            if (need_div) begin
               div_start = 1'b1;
               state_in  = tdmf_pkg::ST_WAIT_X;
            end else begin
               xp_in    = pct_direct;
               state_in = tdmf_pkg::ST_MIX;
            end
         end
         tdmf_pkg::ST_WAIT_X: begin
            if (div_done) begin
               xp_in    = div_quo;
               state_in = tdmf_pkg::ST_MIX;
            end
         end
         tdmf_pkg::ST_MIX: begin
            left_in  = mix_left;
            right_in = mix_right;
            state_in = tdmf_pkg::ST_COMMIT;
         end
         tdmf_pkg::ST_COMMIT: begin
            // route side duties to the half-bridges; centred sample holds
            if (is_fwd) begin
               duty_in[tdmf_pkg::DUTY_LF] = left_duty;
               duty_in[tdmf_pkg::DUTY_LB] = '0;
               duty_in[tdmf_pkg::DUTY_RF] = right_duty;
               duty_in[tdmf_pkg::DUTY_RB] = '0;
               mode_in = tdmf_pkg::MODE_FWD;
            end else if (is_back) begin
               duty_in[tdmf_pkg::DUTY_LF] = '0;
               duty_in[tdmf_pkg::DUTY_LB] = left_duty;
               duty_in[tdmf_pkg::DUTY_RF] = '0;
               duty_in[tdmf_pkg::DUTY_RB] = right_duty;
               mode_in = tdmf_pkg::MODE_BACK;
            end else if (is_rot_l) begin
               duty_in[tdmf_pkg::DUTY_LF] = '0;
               duty_in[tdmf_pkg::DUTY_LB] = left_duty;
               duty_in[tdmf_pkg::DUTY_RF] = left_duty;
               duty_in[tdmf_pkg::DUTY_RB] = '0;
               mode_in = tdmf_pkg::MODE_ROT_L;
            end else if (is_rot_r) begin
               duty_in[tdmf_pkg::DUTY_LF] = right_duty;
               duty_in[tdmf_pkg::DUTY_LB] = '0;
               duty_in[tdmf_pkg::DUTY_RF] = '0;
               duty_in[tdmf_pkg::DUTY_RB] = right_duty;
               mode_in = tdmf_pkg::MODE_ROT_R;
            end else begin
               mode_in = tdmf_pkg::MODE_HELD;
            end
            // every sample rearms the failsafe
            count_in = timeout_ff;
            armed_in = 1'b1;
            state_in = tdmf_pkg::ST_OUT;
         end
         tdmf_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = tdmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdmf_pkg::ST_IDLE;
         count_ff <= '0;
         armed_ff <= 1'b0;
         for (int i = 0; i < tdmf_pkg::NUM_DUTIES; i++) begin
            duty_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         armed_ff <= armed_in;
         duty_ff  <= duty_in;
      end
      x_ff       <= x_in;
      y_ff       <= y_in;
      yp_ff      <= yp_in;
      xp_ff      <= xp_in;
      left_ff    <= left_in;
      right_ff   <= right_in;
      mode_ff    <= mode_in;
      expired_ff <= expired_in;
   end

   // Register file: writes beyond the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         db_low_ff     <= tdmf_pkg::DB_LOW_RESET;
         db_high_ff    <= tdmf_pkg::DB_HIGH_RESET;
         full_scale_ff <= tdmf_pkg::FULL_SCALE_RESET;
         duty_limit_ff <= tdmf_pkg::DUTY_LIMIT_RESET;
         limit_en_ff   <= tdmf_pkg::LIMIT_EN_RESET;
         timeout_ff    <= tdmf_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            tdmf_pkg::REG_DB_LOW:     db_low_ff     <= csr_wdata[SB-1:0];
            tdmf_pkg::REG_DB_HIGH:    db_high_ff    <= csr_wdata[SB-1:0];
            tdmf_pkg::REG_FULL_SCALE: full_scale_ff <= csr_wdata[SB-1:0];
            tdmf_pkg::REG_DUTY_LIMIT: duty_limit_ff <= csr_wdata[tdmf_pkg::LIMIT_BITS-1:0];
            tdmf_pkg::REG_LIMIT_EN:   limit_en_ff   <= csr_wdata[0];
            tdmf_pkg::REG_TIMEOUT:    timeout_ff    <= csr_wdata[tdmf_pkg::TIMER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == tdmf_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == tdmf_pkg::ST_OUT);
   assign rsp_tdata  = tdmf_pkg::RSP_DATA_W'({duty_ff[tdmf_pkg::DUTY_RB],
                                              duty_ff[tdmf_pkg::DUTY_RF],
                                              duty_ff[tdmf_pkg::DUTY_LB],
                                              duty_ff[tdmf_pkg::DUTY_LF]});
   assign rsp_tuser  = {expired_ff, mode_ff};

`ifndef SYNTHESIS
   a_disarmed_count_zero: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (count_ff == '0))
      else $error("failsafe count nonzero while disarmed");

   a_timeout_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && expired_ff) |->
         (mode_ff == tdmf_pkg::MODE_STOP) && !armed_ff && (rsp_tdata == '0))
      else $error("timeout result without stopped duties");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new item taken while one is in flight");
`endif

endmodule
